[design/bsd_pkg.sv]
// ----------------------------------------------------------------------------
// bsd_pkg: shared types and constants for the block statistics unit
//
// Field widths of the sample and result transfers, and the packed structs
// that carry them across the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

package bsd_pkg;

    // Fixed field widths of the transfers.
    localparam int SAMPLE_W = 16;
    localparam int TOTAL_W  = 26;
    localparam int MEAN_W   = 24;
    localparam int DEV_W    = 24;
    localparam int COUNT_W  = 11;

    // One input sample.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } item_t;

    // One block result.
    typedef struct packed {
        logic signed [TOTAL_W-1:0]  total;
        logic signed [SAMPLE_W-1:0] smallest;
        logic signed [SAMPLE_W-1:0] largest;
        logic signed [MEAN_W-1:0]   mean_q8;
        logic        [DEV_W-1:0]    dev_min_q8;
        logic        [DEV_W-1:0]    dev_max_q8;
        logic        [COUNT_W-1:0]  sample_count;
        logic                       overflowed;
    } result_t;

endpackage

`default_nettype wire

[design/bsd_ram.sv]
// ----------------------------------------------------------------------------
// bsd_ram: simple dual-port RAM
//
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read request.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic                                         re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[design/bsd_div.sv]
// ----------------------------------------------------------------------------
// bsd_div: iterative unsigned divider
//
// Restoring division, one quotient bit per cycle. A start pulse loads the
// operands; done pulses for one cycle when the quotient is valid. The divisor
// must be nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module bsd_div #(
    parameter int NW = 43,
    parameter int DW = 11
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               done,
    output logic [NW-1:0]      quotient
);

    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0] acc_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dvs_reg;
    logic [KW-1:0] step_reg;
    logic          run_reg;
    logic          done_reg;

    logic [DW:0]   trial;
    logic          fits;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] acc_next;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        trial    = {rem_reg, acc_reg[NW-1]};
        fits     = trial >= {1'b0, dvs_reg};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
        acc_next = {acc_reg[NW-2:0], fits};
    end

    // Step counter and operand registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            acc_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= KW'(NW);
                acc_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end
            else if (run_reg)
            begin
                acc_reg  <= acc_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg - KW'(1);
                if (step_reg == KW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

`default_nettype wire

[design/block_statistics_with_deviation.sv]
// ----------------------------------------------------------------------------
// block_statistics_with_deviation: min, max, mean and deviation range
//
// Stores a block of signed samples, keeps running sum, min, max and count,
// then divides for the Q.8 mean and scans the stored block for the smallest
// and largest absolute deviation from that mean.
//
//   Channel   Signals              Direction  Transfer
//   -------   -------------------  ---------  --------------------------------
//   sample    start, busy, item    in         edge with start high, busy low
//   result    done, result         out        edge ending the cycle done is high
//
// A sample without the last flag leaves busy low. A sample with the last flag
// keeps busy high while the one-bit-per-cycle divider runs its NW steps,
// where NW = 24 + clog2(MAX_SAMPLES + 1), and while the stored samples are
// read back one per cycle through the sample RAM's read port. Reset needs no
// clearing pass: only entries written in the current block are read. The
// result is shown for one cycle and the receiver cannot stall it; busy is low
// again in that same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module block_statistics_with_deviation #(
    parameter int MAX_SAMPLES = 1024
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire bsd_pkg::item_t   item,
    output logic                  done,
    output bsd_pkg::result_t      result
);

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SW  = bsd_pkg::SAMPLE_W + CW;
    localparam int NW  = SW + 8;
    localparam int SXW = (SW > bsd_pkg::TOTAL_W) ? SW : bsd_pkg::TOTAL_W;
    localparam int CXW = (CW > bsd_pkg::COUNT_W) ? CW : bsd_pkg::COUNT_W;
    localparam int MW  = bsd_pkg::MEAN_W;
    localparam int VW  = bsd_pkg::DEV_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SCAN
    } state_t;

    state_t                           state_reg;
    logic signed [SW-1:0]             sum_reg;
    logic signed [bsd_pkg::SAMPLE_W-1:0] min_reg;
    logic signed [bsd_pkg::SAMPLE_W-1:0] max_reg;
    logic [CW-1:0]                    fill_reg;
    logic                             ovf_reg;
    logic signed [MW-1:0]             mean_reg;
    logic [CW-1:0]                    scan_reg;
    logic                             rd_valid_reg;
    logic                             first_reg;
    logic [VW-1:0]                    dmin_reg;
    logic [VW-1:0]                    dmax_reg;
    logic                             done_reg;
    bsd_pkg::result_t                 result_reg;

    logic signed [SW-1:0]             sum_next;
    logic signed [bsd_pkg::SAMPLE_W-1:0] min_next;
    logic signed [bsd_pkg::SAMPLE_W-1:0] max_next;
    logic [CW-1:0]                    fill_next;

    logic                             accept;
    logic                             store_ok;
    logic                             rd_en;
    logic                             finish;
    logic [bsd_pkg::SAMPLE_W-1:0]     rd_data;
    logic signed [bsd_pkg::SAMPLE_W-1:0] rd_sample;

    logic [SW-1:0]                    sum_mag;
    logic                             div_done;
    logic [NW-1:0]                    quotient;
    logic [MW:0]                      mean_mag;
    logic [MW:0]                      mean_signed;

    logic signed [VW:0]               dev_diff;
    logic [VW:0]                      dev_neg;
    logic [VW-1:0]                    dev_abs;

    logic signed [SXW-1:0]            sum_ext;
    logic [CXW-1:0]                   fill_ext;

    // Sample transfer and the running statistics it updates.
    assign accept   = start && (state_reg == ST_IDLE);
    assign store_ok = fill_reg != MAX_CNT;

    always_comb
    begin
        sum_next  = sum_reg + SW'(item.sample);
        fill_next = fill_reg + CW'(1);
        min_next  = ((fill_reg == '0) || (item.sample < min_reg)) ? item.sample : min_reg;
        max_next  = ((fill_reg == '0) || (item.sample > max_reg)) ? item.sample : max_reg;
    end

    // Sample store.
    bsd_ram #(
        .WIDTH (bsd_pkg::SAMPLE_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (accept && store_ok),
        .waddr (fill_reg[AW-1:0]),
        .wdata (item.sample),
        .re    (rd_en),
        .raddr (scan_reg[AW-1:0]),
        .rdata (rd_data)
    );

    // Mean: divide |sum| * 256 by the count, then restore the sign.
    assign sum_mag = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);

    bsd_div #(
        .NW (NW),
        .DW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_DIV_GO),
        .dividend ({sum_mag, 8'h00}),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        mean_mag    = {1'b0, quotient[MW-1:0]};
        mean_signed = sum_reg[SW-1] ? (MW + 1)'(-mean_mag) : mean_mag;
    end

    // Absolute deviation of the sample read back from the store. Both
    // operands are sign-extended to the full difference width.
    assign rd_sample = rd_data;

    always_comb
    begin
        dev_diff = {rd_sample[bsd_pkg::SAMPLE_W-1], rd_sample, 8'h00}
                 - {mean_reg[MW-1], mean_reg};
        dev_neg  = (VW + 1)'(-dev_diff);
        dev_abs  = dev_diff[VW] ? dev_neg[VW-1:0] : dev_diff[VW-1:0];
    end

    // Scan control: issue one read a cycle, finish once the last one is used.
    assign rd_en  = (state_reg == ST_SCAN) && (scan_reg != fill_reg);
    assign finish = (state_reg == ST_SCAN) && (scan_reg == fill_reg) && !rd_valid_reg;

    // Result field extension to the fixed port widths.
    assign sum_ext  = SXW'(sum_reg);
    assign fill_ext = CXW'(fill_reg);

    // Sequencer with its registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sum_reg      <= '0;
            min_reg      <= '0;
            max_reg      <= '0;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            mean_reg     <= '0;
            scan_reg     <= '0;
            rd_valid_reg <= 1'b0;
            first_reg    <= 1'b0;
            dmin_reg     <= '0;
            dmax_reg     <= '0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            done_reg     <= 1'b0;
            rd_valid_reg <= rd_en;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (store_ok)
                        begin
                            sum_reg  <= sum_next;
                            min_reg  <= min_next;
                            max_reg  <= max_next;
                            fill_reg <= fill_next;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (item.last)
                        begin
                            state_reg <= ST_DIV_GO;
                        end
                    end
                end
                ST_DIV_GO:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        mean_reg  <= mean_signed[MW-1:0];
                        scan_reg  <= '0;
                        first_reg <= 1'b1;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (rd_en)
                    begin
                        scan_reg <= scan_reg + CW'(1);
                    end
                    if (rd_valid_reg)
                    begin
                        first_reg <= 1'b0;
                        if (first_reg || (dev_abs < dmin_reg))
                        begin
                            dmin_reg <= dev_abs;
                        end
                        if (first_reg || (dev_abs > dmax_reg))
                        begin
                            dmax_reg <= dev_abs;
                        end
                    end
                    if (finish)
                    begin
                        result_reg.total        <= sum_ext[bsd_pkg::TOTAL_W-1:0];
                        result_reg.smallest     <= min_reg;
                        result_reg.largest      <= max_reg;
                        result_reg.mean_q8      <= mean_reg;
                        result_reg.dev_min_q8   <= dmin_reg;
                        result_reg.dev_max_q8   <= dmax_reg;
                        result_reg.sample_count <= fill_ext[bsd_pkg::COUNT_W-1:0];
                        result_reg.overflowed   <= ovf_reg;
                        done_reg  <= 1'b1;
                        sum_reg   <= '0;
                        min_reg   <= '0;
                        max_reg   <= '0;
                        fill_reg  <= '0;
                        ovf_reg   <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = state_reg != ST_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[tb/sv/tb_block_statistics_with_deviation.sv]
// ----------------------------------------------------------------------------
// tb_block_statistics_with_deviation: self-checking bench for block statistics
//
// Feeds blocks of signed samples through the start/busy command port and
// predicts each block's sum, min, max, Q.8 mean and deviation range. Every
// result strobe is checked field by field against the oldest prediction.
// Directed blocks cover the extremes, truncation of negative means, min and
// max tracking and blocks of equal samples. Random blocks of mixed length and
// content follow, with random idle gaps and at least one full drain of the
// result side.
// ----------------------------------------------------------------------------
module tb_block_statistics_with_deviation;

    localparam int DEPTH        = 1024;
    localparam int RANDOM_ITEMS = 660;
    localparam int SETTLE       = 64;

    // One queued sample, optionally held back until all results are in.
    typedef struct packed {
        logic           drain;
        bsd_pkg::item_t payload;
    } queued_sample_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    bsd_pkg::item_t   item = '0;
    logic             busy;
    logic             done;
    bsd_pkg::result_t result;

    queued_sample_t   sample_queue[$];
    bsd_pkg::result_t expected_stats[$];
    int               outstanding = 0;
    int               calm_left = 0;

    // Running block state of the predictor.
    logic signed [bsd_pkg::SAMPLE_W-1:0] held[DEPTH];
    longint                     acc = 0;
    int                         lo = 0;
    int                         hi = 0;
    int                         fill = 0;
    logic                       dropped = 1'b0;

    int mismatches = 0;
    int blocks_checked = 0;
    int samples_taken = 0;
    int overflow_blocks = 0;

    block_statistics_with_deviation #(
        .MAX_SAMPLES(DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .item  (item),
        .done  (done),
        .result(result)
    );

    // Clock and reset.
    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Idle length after a transfer: mostly none or short, a few long, and
    // occasional stretches with no idling at all.
    function automatic int next_gap();
        int roll;
        if (calm_left != 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            calm_left = $urandom_range(20, 120);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Fold one accepted sample into the block state; on the last sample,
    // queue the expected statistics and clear the block.
    task automatic take_sample(input bsd_pkg::item_t it);
        longint           mean_q8;
        longint           dev;
        longint           dev_lo;
        longint           dev_hi;
        bsd_pkg::result_t want;
        samples_taken++;
        if (fill < DEPTH)
        begin
            held[fill] = it.sample;
            if (fill == 0)
            begin
                lo = it.sample;
                hi = it.sample;
            end
            else
            begin
                if (it.sample < lo)
                    lo = it.sample;
                if (it.sample > hi)
                    hi = it.sample;
            end
            acc += it.sample;
            fill++;
        end
        else
            dropped = 1'b1;

        if (it.last)
        begin
            mean_q8 = 0;
            dev_lo = 0;
            dev_hi = 0;
            if (fill != 0)
            begin
                // Integer division truncates toward zero, as the mean requires.
                mean_q8 = (acc * 256) / fill;
                for (int i = 0; i < fill; i++)
                begin
                    dev = longint'(held[i]) * 256 - mean_q8;
                    if (dev < 0)
                        dev = -dev;
                    if (i == 0 || dev < dev_lo)
                        dev_lo = dev;
                    if (i == 0 || dev > dev_hi)
                        dev_hi = dev;
                end
            end
            want.total        = bsd_pkg::TOTAL_W'(acc);
            want.smallest     = bsd_pkg::SAMPLE_W'(lo);
            want.largest      = bsd_pkg::SAMPLE_W'(hi);
            want.mean_q8      = bsd_pkg::MEAN_W'(mean_q8);
            want.dev_min_q8   = bsd_pkg::DEV_W'(dev_lo);
            want.dev_max_q8   = bsd_pkg::DEV_W'(dev_hi);
            want.sample_count = bsd_pkg::COUNT_W'(fill);
            want.overflowed   = dropped;
            if (dropped)
                overflow_blocks++;
            expected_stats.push_back(want);
            acc = 0;
            lo = 0;
            hi = 0;
            fill = 0;
            dropped = 1'b0;
        end
    endtask

    task automatic check_field(input string label, input longint want, input longint got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch in %s of block %0d: expected %0d, got %0d",
                         label, blocks_checked, want, got);
        end
    endtask

    task automatic add_sample(input int value, input bit is_last, input bit drain = 1'b0);
        queued_sample_t q;
        q.drain          = drain;
        q.payload.sample = bsd_pkg::SAMPLE_W'(value);
        q.payload.last   = is_last;
        sample_queue.push_back(q);
    endtask

    // Driver: presents queued samples and holds each until its transfer.
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        bit took;
        int idle_left;
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
            idle_left = 0;
        end
        else
        begin
            took = start && !busy;
            if (start && !took)
            begin
                // Still waiting for the transfer: hold the sample.
            end
            else if (idle_left != 0)
            begin
                start <= 1'b0;
                idle_left--;
            end
            else if (sample_queue.size() != 0 &&
                     (!sample_queue[0].drain ||
                      (outstanding == 0 && !(took && item.last))))
            begin
                start <= 1'b1;
                item <= sample_queue[0].payload;
                void'(sample_queue.pop_front());
                idle_left = next_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: checks result strobes and predicts from accepted samples.
    always @(posedge clk)
    begin : stats_monitor
        bsd_pkg::result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_stats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result: total %0d, count %0d",
                                 result.total, result.sample_count);
                end
                else
                begin
                    want = expected_stats.pop_front();
                    check_field("total", want.total, result.total);
                    check_field("smallest", want.smallest, result.smallest);
                    check_field("largest", want.largest, result.largest);
                    check_field("mean_q8", want.mean_q8, result.mean_q8);
                    check_field("dev_min_q8", want.dev_min_q8, result.dev_min_q8);
                    check_field("dev_max_q8", want.dev_max_q8, result.dev_max_q8);
                    check_field("sample_count", want.sample_count, result.sample_count);
                    check_field("overflowed", want.overflowed, result.overflowed);
                    blocks_checked++;
                end
            end
            if (start && !busy)
                take_sample(item);
            outstanding <= expected_stats.size();
        end
    end

    // Stimulus and end of run.
    initial
    begin : stimulus
        int added;
        int len;
        int mode;
        int base;
        int spread;
        int value;

        // Single-sample blocks at the extremes and at zero.
        add_sample(32767, 1'b1);
        add_sample(-32768, 1'b1);
        add_sample(0, 1'b1);
        // Means that truncate toward zero from both sides.
        add_sample(-1, 1'b0);
        add_sample(0, 1'b0);
        add_sample(0, 1'b1);
        add_sample(1, 1'b0);
        add_sample(0, 1'b0);
        add_sample(0, 1'b1);
        add_sample(-32768, 1'b0);
        add_sample(32767, 1'b1);
        // The first sample sets both min and max; later ones move them.
        // This block also waits until every earlier result has come back.
        add_sample(5, 1'b0, 1'b1);
        add_sample(-3, 1'b0);
        add_sample(7, 1'b0);
        add_sample(2, 1'b1);
        add_sample(100, 1'b0);
        add_sample(-5, 1'b0);
        add_sample(50, 1'b1);
        // Equal samples give zero deviation.
        add_sample(-7, 1'b0);
        add_sample(-7, 1'b0);
        add_sample(-7, 1'b1);

        // Random blocks of mixed length and content.
        added = 0;
        while (added < RANDOM_ITEMS)
        begin
            mode = $urandom_range(0, 3);
            value = $urandom_range(0, 99);
            if (value < 70)
                len = $urandom_range(1, 12);
            else if (value < 95)
                len = $urandom_range(13, 60);
            else
                len = $urandom_range(61, 300);
            base = $urandom_range(0, 65535) - 32768;
            spread = $urandom_range(0, 255);
            for (int i = 0; i < len; i++)
            begin
                case (mode)
                    0: value = $urandom_range(0, 65535) - 32768;
                    1: value = base + $urandom_range(0, 2 * spread) - spread;
                    2: value = base;
                    default:
                        case ($urandom_range(0, 2))
                            0: value = -32768;
                            1: value = 32767;
                            default: value = $urandom_range(0, 65535) - 32768;
                        endcase
                endcase
                if (value > 32767)
                    value = 32767;
                if (value < -32768)
                    value = -32768;
                add_sample(value, i == len - 1, i == 0 && $urandom_range(0, 14) == 0);
            end
            added += len;
        end

        // Wait for every transfer, then every result, then a quiet tail.
        @(negedge clk);
        while (sample_queue.size() != 0 || start)
            @(negedge clk);
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("Checked %0d blocks built from %0d accepted samples.",
                 blocks_checked, samples_taken);
        $display("%0d blocks overflowed the store; %0d mismatches found.",
                 overflow_blocks, mismatches);
        if (mismatches == 0 && expected_stats.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2500000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
